// File: sv/relative_strength_index_unit_assert.svh
// assertion macros for the relative strength index unit
`ifndef RELATIVE_STRENGTH_INDEX_UNIT_ASSERT_SVH
`define RELATIVE_STRENGTH_INDEX_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RSI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define RSI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RSI_ASSERT_IMP(lbl, ante, cons, msg)
`define RSI_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: sv/rsi_pkg.sv
// shared constants and types for the relative strength index unit
`timescale 1ns / 1ps
package rsi_pkg;

  localparam int PRICE_W  = 32;
  localparam int PERIOD_W = 11;
  localparam int FRAC_W   = 16;
  localparam int AVG_W    = 64;
  localparam int DVD_W    = AVG_W + FRAC_W;
  localparam int SMOOTH_W = AVG_W + 1;
  localparam int STEP_W   = $clog2(DVD_W);
  localparam int RSI_BITS = 23;
  localparam int BIT_W    = $clog2(RSI_BITS);

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(14);
  localparam logic [PERIOD_W-1:0] PERIOD_MAX   = PERIOD_W'(1024);
  localparam logic [PERIOD_W-1:0] COUNT_MAX    = PERIOD_W'(1025);
  localparam logic [RSI_BITS-1:0] RSI_FULL     = RSI_BITS'(6553600);

  typedef enum logic [1:0] {
    ALU_IDLE,
    ALU_LOAD,
    ALU_DIV,
    ALU_ADD
  } alu_op_e;

  typedef struct packed {
    alu_op_e           op;
    logic [DVD_W-1:0]  dividend;
    logic [AVG_W-1:0]  divisor;
    logic [AVG_W-1:0]  addend;
  } alu_cmd_t;

  typedef struct packed {
    logic                valid;
    logic [RSI_BITS-1:0] rsi;
    logic                short_series;
  } emit_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHANGE,
    ST_LOAD,
    ST_RUN,
    ST_DONE,
    ST_POST,
    ST_R_LOAD,
    ST_R_SHIFT,
    ST_R_ADD,
    ST_EMIT
  } ctrl_state_e;

endpackage

// File: sv/rsi_if.sv
// valid/ready channel interfaces for samples, results and the period register
`timescale 1ns / 1ps
interface rsi_in_if;
  logic                         valid;
  logic                         ready;
  logic [rsi_pkg::PRICE_W-1:0]  price;
  logic                         last;
  modport source (output valid, price, last, input ready);
  modport sink (input valid, price, last, output ready);
endinterface

interface rsi_out_if;
  logic                         valid;
  logic                         ready;
  logic [rsi_pkg::RSI_BITS-1:0] rsi;
  logic                         short_series;
  modport source (output valid, rsi, short_series, input ready);
  modport sink (input valid, rsi, short_series, output ready);
endinterface

interface rsi_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rsi_pkg::PERIOD_W-1:0] period;
  modport source (output valid, period, input ready);
  modport sink (input valid, period, output ready);
endinterface

// File: sv/rsi_alu.sv
// shared compare-subtract unit: one quotient bit or one add step per cycle
`timescale 1ns / 1ps
module rsi_alu (
  input  logic                        clk_i,
  input  rsi_pkg::alu_cmd_t           cmd_i,
  output logic [rsi_pkg::AVG_W-1:0]   quo_o
);

  logic [rsi_pkg::AVG_W-1:0] rem_q, rem_d;
  logic [rsi_pkg::AVG_W-1:0] quo_q, quo_d;
  logic [rsi_pkg::DVD_W-1:0] dvd_q, dvd_d;
  logic [rsi_pkg::AVG_W-1:0] dsr_q, dsr_d;
  logic [rsi_pkg::AVG_W-1:0] add_q, add_d;
  logic [rsi_pkg::AVG_W-1:0] acc;
  logic [rsi_pkg::AVG_W-1:0] diff;
  logic                      ge;

  // remainder arithmetic wraps at the register width
  always_comb begin
    if (cmd_i.op == rsi_pkg::ALU_ADD) begin
      acc = rem_q + add_q;
    end else begin
      acc = {rem_q[rsi_pkg::AVG_W-2:0], dvd_q[rsi_pkg::DVD_W-1]};
    end
    ge   = (acc >= dsr_q);
    diff = acc - dsr_q;
  end

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    dvd_d = dvd_q;
    dsr_d = dsr_q;
    add_d = add_q;
    unique case (cmd_i.op)
      rsi_pkg::ALU_LOAD: begin
        rem_d = '0;
        quo_d = '0;
        dvd_d = cmd_i.dividend;
        dsr_d = cmd_i.divisor;
        add_d = cmd_i.addend;
      end
      rsi_pkg::ALU_DIV: begin
        rem_d = ge ? diff : acc;
        quo_d = {quo_q[rsi_pkg::AVG_W-2:0], ge};
        dvd_d = {dvd_q[rsi_pkg::DVD_W-2:0], 1'b0};
      end
      rsi_pkg::ALU_ADD: begin
        rem_d = ge ? diff : acc;
        quo_d = quo_q + {{(rsi_pkg::AVG_W-1){1'b0}}, ge};
      end
      rsi_pkg::ALU_IDLE: begin
        rem_d = rem_q;
      end
      default: begin
        rem_d = rem_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    add_q <= add_d;
  end

  assign quo_o = quo_q;

endmodule

// File: sv/rsi_ctrl.sv
// sequencer and series state: change split, warm-up sums, smoothing, final ratio
`timescale 1ns / 1ps
module rsi_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rsi_pkg::PRICE_W-1:0]   price_i,
  input  logic                          last_i,
  input  logic [rsi_pkg::PERIOD_W-1:0]  period_i,
  input  logic                          out_free_i,
  output rsi_pkg::emit_t                emit_o,
  output rsi_pkg::alu_cmd_t             alu_cmd_o,
  input  logic [rsi_pkg::AVG_W-1:0]     quo_i
);

  rsi_pkg::ctrl_state_e state_q, state_d;

  logic [rsi_pkg::PRICE_W-1:0]  price_q;
  logic                         last_q;
  logic [rsi_pkg::PRICE_W-1:0]  prev_q;
  logic [rsi_pkg::PERIOD_W-1:0] count_q;
  logic [rsi_pkg::AVG_W-1:0]    gain_q;
  logic [rsi_pkg::AVG_W-1:0]    loss_q;
  logic [rsi_pkg::PRICE_W-1:0]  up_q;
  logic [rsi_pkg::PRICE_W-1:0]  down_q;
  logic                         smooth_q;
  logic                         side_q;
  logic                         add_ge_q;
  logic [rsi_pkg::STEP_W-1:0]   step_q;
  logic [rsi_pkg::BIT_W-1:0]    bit_q;

  logic                         first;
  logic                         warm;
  logic                         warm_end;
  logic                         short_s;
  logic                         loss_zero;
  logic [rsi_pkg::PRICE_W-1:0]  up;
  logic [rsi_pkg::PRICE_W-1:0]  down;
  logic [rsi_pkg::AVG_W-1:0]    cur_avg;
  logic [rsi_pkg::PRICE_W-1:0]  cur_chg;
  logic [rsi_pkg::AVG_W-1:0]    add_fx;
  logic                         add_ge;
  logic [rsi_pkg::SMOOTH_W-1:0] sm_dvd;
  logic [rsi_pkg::AVG_W-1:0]    new_avg;

  always_comb begin
    first     = (count_q == '0);
    warm      = (count_q <= period_i);
    warm_end  = (count_q == period_i);
    short_s   = (count_q <= period_i);
    loss_zero = (loss_q == '0);
    if (price_q > prev_q) begin
      up   = price_q - prev_q;
      down = '0;
    end else begin
      up   = '0;
      down = prev_q - price_q;
    end
    cur_avg = side_q ? loss_q : gain_q;
    cur_chg = side_q ? down_q : up_q;
    add_fx  = {{(rsi_pkg::AVG_W-rsi_pkg::PRICE_W-rsi_pkg::FRAC_W){1'b0}},
               cur_chg, {rsi_pkg::FRAC_W{1'b0}}};
    add_ge  = (add_fx >= cur_avg);
    // avg + floor((add-avg)/p), negative side rounded via +p-1
    if (add_ge) begin
      sm_dvd = {1'b0, add_fx - cur_avg};
    end else begin
      sm_dvd = {1'b0, cur_avg} - {1'b0, add_fx}
             + {{(rsi_pkg::SMOOTH_W-rsi_pkg::PERIOD_W){1'b0}}, period_i}
             - rsi_pkg::SMOOTH_W'(1);
    end
    if (smooth_q) begin
      new_avg = add_ge_q ? (cur_avg + quo_i) : (cur_avg - quo_i);
    end else begin
      new_avg = quo_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rsi_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = rsi_pkg::ST_CHANGE;
      end
      rsi_pkg::ST_CHANGE: begin
        if (first || (warm && !warm_end)) state_d = rsi_pkg::ST_POST;
        else state_d = rsi_pkg::ST_LOAD;
      end
      rsi_pkg::ST_LOAD: state_d = rsi_pkg::ST_RUN;
      rsi_pkg::ST_RUN: begin
        if (step_q == '0) state_d = rsi_pkg::ST_DONE;
      end
      rsi_pkg::ST_DONE: begin
        state_d = side_q ? rsi_pkg::ST_POST : rsi_pkg::ST_LOAD;
      end
      rsi_pkg::ST_POST: begin
        if (!last_q) state_d = rsi_pkg::ST_IDLE;
        else if (short_s || loss_zero) state_d = rsi_pkg::ST_EMIT;
        else state_d = rsi_pkg::ST_R_LOAD;
      end
      rsi_pkg::ST_R_LOAD: state_d = rsi_pkg::ST_R_SHIFT;
      rsi_pkg::ST_R_SHIFT: begin
        if (rsi_pkg::RSI_FULL[bit_q]) state_d = rsi_pkg::ST_R_ADD;
        else if (bit_q == '0) state_d = rsi_pkg::ST_EMIT;
      end
      rsi_pkg::ST_R_ADD: begin
        state_d = (bit_q == '0) ? rsi_pkg::ST_EMIT : rsi_pkg::ST_R_SHIFT;
      end
      rsi_pkg::ST_EMIT: begin
        if (out_free_i) state_d = rsi_pkg::ST_IDLE;
      end
      default: state_d = rsi_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o         = 1'b0;
    alu_cmd_o.op       = rsi_pkg::ALU_IDLE;
    alu_cmd_o.dividend = '0;
    alu_cmd_o.divisor  = {{(rsi_pkg::AVG_W-rsi_pkg::PERIOD_W){1'b0}}, period_i};
    alu_cmd_o.addend   = '0;
    emit_o.valid        = 1'b0;
    emit_o.short_series = short_s;
    if (short_s) emit_o.rsi = '0;
    else if (loss_zero) emit_o.rsi = rsi_pkg::RSI_FULL;
    else emit_o.rsi = quo_i[rsi_pkg::RSI_BITS-1:0];
    unique case (state_q)
      rsi_pkg::ST_IDLE: in_ready_o = 1'b1;
      rsi_pkg::ST_LOAD: begin
        alu_cmd_o.op = rsi_pkg::ALU_LOAD;
        if (smooth_q) begin
          alu_cmd_o.dividend = {sm_dvd, {(rsi_pkg::DVD_W-rsi_pkg::SMOOTH_W){1'b0}}};
        end else begin
          alu_cmd_o.dividend = {cur_avg, {rsi_pkg::FRAC_W{1'b0}}};
        end
      end
      rsi_pkg::ST_RUN: alu_cmd_o.op = rsi_pkg::ALU_DIV;
      rsi_pkg::ST_R_LOAD: begin
        alu_cmd_o.op      = rsi_pkg::ALU_LOAD;
        alu_cmd_o.divisor = gain_q + loss_q;
        alu_cmd_o.addend  = gain_q;
      end
      rsi_pkg::ST_R_SHIFT: alu_cmd_o.op = rsi_pkg::ALU_DIV;
      rsi_pkg::ST_R_ADD: alu_cmd_o.op = rsi_pkg::ALU_ADD;
      rsi_pkg::ST_EMIT: emit_o.valid = 1'b1;
      default: in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rsi_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // series state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      count_q <= '0;
      gain_q  <= '0;
      loss_q  <= '0;
    end else begin
      priority if (state_q == rsi_pkg::ST_CHANGE) begin
        prev_q <= price_q;
        if (count_q < rsi_pkg::COUNT_MAX) count_q <= count_q + rsi_pkg::PERIOD_W'(1);
        if (!first && warm) begin
          gain_q <= gain_q + {{(rsi_pkg::AVG_W-rsi_pkg::PRICE_W){1'b0}}, up};
          loss_q <= loss_q + {{(rsi_pkg::AVG_W-rsi_pkg::PRICE_W){1'b0}}, down};
        end
      end else if (state_q == rsi_pkg::ST_DONE) begin
        if (side_q) loss_q <= new_avg;
        else gain_q <= new_avg;
      end else if (state_q == rsi_pkg::ST_EMIT && out_free_i) begin
        prev_q  <= '0;
        count_q <= '0;
        gain_q  <= '0;
        loss_q  <= '0;
      end else begin
        count_q <= count_q;
      end
    end
  end

  // item latch, step and bit counters
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      rsi_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          price_q <= price_i;
          last_q  <= last_i;
        end
      end
      rsi_pkg::ST_CHANGE: begin
        up_q     <= up;
        down_q   <= down;
        smooth_q <= !warm;
        side_q   <= 1'b0;
      end
      rsi_pkg::ST_LOAD: begin
        add_ge_q <= add_ge;
        step_q   <= smooth_q ? rsi_pkg::STEP_W'(rsi_pkg::SMOOTH_W - 1)
                             : rsi_pkg::STEP_W'(rsi_pkg::DVD_W - 1);
      end
      rsi_pkg::ST_RUN: begin
        if (step_q != '0) step_q <= step_q - rsi_pkg::STEP_W'(1);
      end
      rsi_pkg::ST_DONE: side_q <= 1'b1;
      rsi_pkg::ST_R_LOAD: bit_q <= rsi_pkg::BIT_W'(rsi_pkg::RSI_BITS - 1);
      rsi_pkg::ST_R_SHIFT: begin
        if (!rsi_pkg::RSI_FULL[bit_q] && bit_q != '0) bit_q <= bit_q - rsi_pkg::BIT_W'(1);
      end
      rsi_pkg::ST_R_ADD: begin
        if (bit_q != '0) bit_q <= bit_q - rsi_pkg::BIT_W'(1);
      end
      default: begin
        bit_q <= bit_q;
      end
    endcase
  end

endmodule

// File: sv/relative_strength_index_unit.sv
// top level of the relative strength index unit
`timescale 1ns / 1ps
`include "relative_strength_index_unit_assert.svh"
// Wilder RSI over a stream of price samples. Each accepted item is one price;
// the item flagged last closes the series, produces one result (RSI in Q7.16,
// or 0 with short_series set if fewer than period+1 samples came in) and
// clears the series state; the period register keeps its value. Items are
// taken one at a time and the sample channel is not ready while one is in
// work. Work per item runs on the single 64-bit compare-subtract unit that
// retires one quotient bit per cycle: a plain warm-up sample needs no
// division; the sample that closes warm-up needs two 80-step divisions by
// the period; each smoothed sample needs two 65-step divisions; a last item
// that needs the gain/(gain+loss) ratio adds one load step, 23 shift steps
// plus 3 add steps for it, and every last item then hands over its result,
// held back while the previous result still waits in the output register.
// A finished result sits in an output register, so the next sample is taken
// while it waits. No clearing pass is needed after reset.
module relative_strength_index_unit (
  input  logic    clk_i,
  input  logic    rst_ni,
  rsi_cfg_if.sink cfg_i,
  rsi_in_if.sink  smp_i,
  rsi_out_if.source res_o
);

  logic [rsi_pkg::PERIOD_W-1:0] period_q;
  logic [rsi_pkg::PERIOD_W-1:0] period_eff;
  logic                         res_valid_q;
  logic [rsi_pkg::RSI_BITS-1:0] res_rsi_q;
  logic                         res_short_q;
  logic                         out_free;
  logic                         in_ready;
  rsi_pkg::emit_t               emit;
  rsi_pkg::alu_cmd_t            alu_cmd;
  logic [rsi_pkg::AVG_W-1:0]    quo;

  // period register, to be written by the user only between items; the block itself does not enforce it
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= rsi_pkg::PERIOD_RESET;
    end else if (cfg_i.valid) begin
      period_q <= cfg_i.period;
    end
  end

  // zero acts as one, anything above the maximum as the maximum
  always_comb begin
    priority if (period_q == '0) begin
      period_eff = rsi_pkg::PERIOD_W'(1);
    end else if (period_q > rsi_pkg::PERIOD_MAX) begin
      period_eff = rsi_pkg::PERIOD_MAX;
    end else begin
      period_eff = period_q;
    end
  end

  // sequencer with the series state
  rsi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (smp_i.valid),
    .in_ready_o (in_ready),
    .price_i    (smp_i.price),
    .last_i     (smp_i.last),
    .period_i   (period_eff),
    .out_free_i (out_free),
    .emit_o     (emit),
    .alu_cmd_o  (alu_cmd),
    .quo_i      (quo)
  );

  // shared divider used for the averages and the final ratio
  rsi_alu u_alu (
    .clk_i (clk_i),
    .cmd_i (alu_cmd),
    .quo_o (quo)
  );

  assign smp_i.ready = in_ready;

  // result register between the sequencer and the result channel
  assign out_free = !res_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_free) begin
      res_valid_q <= emit.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid && out_free) begin
      res_rsi_q   <= emit.rsi;
      res_short_q <= emit.short_series;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.rsi          = res_rsi_q;
  assign res_o.short_series = res_short_q;

  // an accepted item keeps the block busy, so the sample channel is not ready in the cycle after
  `RSI_ASSERT_NXT(a_busy_after_accept, smp_i.valid && smp_i.ready, !smp_i.ready, "ready after accept")
  // a short series always reports zero
  `RSI_ASSERT_IMP(a_short_zero, res_valid_q && res_short_q, res_rsi_q == '0, "short series rsi not zero")
  // no result can be pending in the sequencer while it takes samples
  `RSI_ASSERT_IMP(a_idle_no_emit, smp_i.ready, !emit.valid, "emit while idle")

endmodule
